// ----- rtl/wsc_pkg.sv -----
// Shared types and constants for the weighted sigma clip unit.
// Used by the channel interfaces and the top level; depends on nothing.
package wsc_pkg;

  localparam int unsigned ResW   = 16;  // residual, signed Q12.4
  localparam int unsigned WgtW   = 16;  // weight, unsigned Q4.12
  localparam int unsigned CntOutW = 13; // outlier count on the result word
  localparam int unsigned NsigW  = 16;  // nsig_cut, unsigned Q8.8
  localparam int unsigned SwW    = 28;
  localparam int unsigned SfW    = 45;
  localparam int unsigned Sf2W   = 60;
  localparam int unsigned CutW   = 40;
  localparam int unsigned DivW   = 68;  // dividend width, both divisions
  localparam int unsigned SqrtW  = 25;  // root bits
  localparam int unsigned MulW   = 33;  // signed multiplier operand width

  localparam logic [6:0] DivLast  = 7'(DivW - 1);
  localparam logic [6:0] SqrtLast = 7'(SqrtW - 1);

  localparam logic [NsigW-1:0] NsigReset = 16'd1280;
  localparam logic             NsigIdx   = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ,
    S_WR,
    S_WRR,
    S_ACC,
    S_FIN,
    S_DIV_M,
    S_SAT_M,
    S_DIV_E,
    S_SAT_E,
    S_MSQ,
    S_VAR,
    S_SQRT,
    S_MULD,
    S_CUT_HI,
    S_CUT_LO,
    S_CLIP
  } state_e;

endpackage

// ----- rtl/wsc_in_if.sv -----
// Input channel of the weighted sigma clip unit: valid/ready plus pixel word.
// Depends on wsc_pkg for field widths.
interface wsc_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic signed [wsc_pkg::ResW-1:0]  residual;
  logic        [wsc_pkg::WgtW-1:0]  weight;
  logic                             last;

  modport source (output valid, func, residual, weight, last, input ready);
  modport sink   (input valid, func, residual, weight, last, output ready);
endinterface

// ----- rtl/wsc_out_if.sv -----
// Result channel of the weighted sigma clip unit: valid/ready plus result word.
// Depends on wsc_pkg for field widths.
interface wsc_out_if;
  logic                            valid;
  logic                            ready;
  logic [wsc_pkg::WgtW-1:0]        new_weight;
  logic                            is_outlier;
  logic [wsc_pkg::CntOutW-1:0]     outlier_count;
  logic                            clip_active;
  logic                            final_res;

  modport source (output valid, new_weight, is_outlier, outlier_count, clip_active,
                  final_res, input ready);
  modport sink   (input valid, new_weight, is_outlier, outlier_count, clip_active,
                  final_res, output ready);
endinterface

// ----- rtl/weighted_sigma_clip_unit.sv -----
// Weighted sigma clip unit: statistics pass, cut computation and clip pass.
// Depends on wsc_pkg, wsc_in_if and wsc_out_if.
//
// Usage:
//   in_ch carries pixel words (func, residual, weight, last). func 0 words feed
//   the weighted sums and give no result; func 0 with last computes mean,
//   variance, sigma and the cuts. func 1 words are classified against the
//   stored cuts, and each gives one result word on out_ch.
//   A statistics word is accepted, then r*r, w*r and w*r*r go through the
//   shared multiplier, then it is accumulated. The last statistics word then
//   adds two 68-step restoring divisions by the weight sum, one m*m product,
//   a 25-step square root and the nsig*sigma product, all one step per cycle.
//   A clip word is accepted, then classified and loaded into the output
//   register; its result is valid on the cycle after that.
//   in_ch.ready is high only while the sequencer is idle.
//   Stall: the output register holds one result. A new clip word may be taken
//   while it waits; that word then waits in the classify step until the
//   register is taken.
//   Reset: sums, cuts, clip enable and outlier count clear; nsig_cut returns
//   to 5.0 (1280). nsig_cut is written through the APB port, one register at
//   word index 0 (paddr[2] selects the word).
module weighted_sigma_clip_unit #(
  parameter int unsigned MAX_PIXELS = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  wsc_in_if.sink           in_ch,
  wsc_out_if.source        out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CntW = $clog2(MAX_PIXELS + 1);

  // ---------------------------------------------------------------- registers
  wsc_pkg::state_e state_q, state_d;

  logic [wsc_pkg::NsigW-1:0] nsig_q, nsig_d;

  // architectural state
  logic [wsc_pkg::SwW-1:0]         sw_q, sw_d;
  logic [wsc_pkg::SfW-1:0]         sf_q, sf_d;
  logic [wsc_pkg::Sf2W-1:0]        sf2_q, sf2_d;
  logic signed [wsc_pkg::CutW-1:0] up_q, up_d;
  logic signed [wsc_pkg::CutW-1:0] lo_q, lo_d;
  logic                            clip_en_q, clip_en_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;

  // latched input word
  logic signed [wsc_pkg::ResW-1:0] res_q, res_d;
  logic [wsc_pkg::WgtW-1:0]        wgt_q, wgt_d;
  logic                            last_q, last_d;

  // working registers of the sequencer
  logic signed [2*wsc_pkg::MulW-1:0] prod_q, prod_d;
  logic [30:0]                       rr_q, rr_d;
  logic [wsc_pkg::DivW-1:0]          div_num_q, div_num_d;
  logic [wsc_pkg::DivW-1:0]          div_quo_q, div_quo_d;
  logic [wsc_pkg::SwW-1:0]           div_rem_q, div_rem_d;
  logic [2*wsc_pkg::SqrtW-1:0]       sq_src_q, sq_src_d;
  logic [wsc_pkg::SqrtW-1:0]         sq_root_q, sq_root_d;
  logic [wsc_pkg::SqrtW:0]           sq_rem_q, sq_rem_d;
  logic [6:0]                        step_q, step_d;
  logic                              neg_q, neg_d;
  logic [31:0]                       m_q, m_d;
  logic [48:0]                       e2_q, e2_d;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [wsc_pkg::WgtW-1:0]      out_wgt_q, out_wgt_d;
  logic                          out_outl_q, out_outl_d;
  logic [wsc_pkg::CntOutW-1:0]   out_cnt_q, out_cnt_d;
  logic                          out_act_q, out_act_d;
  logic                          out_fin_q, out_fin_d;

  // ------------------------------------------------------------- shared logic
  logic                              in_fire;
  logic                              out_free;
  logic                              cfg_wr;
  logic signed [wsc_pkg::MulW-1:0]   mul_a, mul_b;

  // divider step: shift in one dividend bit, subtract divisor if it fits
  logic [wsc_pkg::SwW:0]   div_trial;
  logic [wsc_pkg::SwW:0]   div_diff;
  logic                    div_ge;

  // square root step: two source bits in, one root bit out
  logic [wsc_pkg::SqrtW+2:0] sq_trial;
  logic [wsc_pkg::SqrtW+2:0] sq_test;
  logic [wsc_pkg::SqrtW+2:0] sq_diff;
  logic                      sq_ge;

  logic [46:0]  msq;
  logic         var_ok;
  logic [44:0]  sf_mag;

  logic signed [41:0] mean42;
  logic signed [41:0] d42;
  logic signed [41:0] add_sum;
  logic signed [wsc_pkg::CutW-1:0] cut_sat;

  logic signed [wsc_pkg::CutW-1:0] r16;
  logic                            outl;
  logic [CntW-1:0]                 cnt_inc;
  logic [CntW+wsc_pkg::CntOutW-1:0] cnt_ext;

  assign in_fire  = in_ch.valid && (state_q == wsc_pkg::S_IDLE);
  assign out_free = !out_valid_q || out_ch.ready;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == wsc_pkg::NsigIdx);

  assign div_trial = {div_rem_q, div_num_q[wsc_pkg::DivW-1]};
  assign div_diff  = div_trial - {1'b0, sw_q};
  assign div_ge    = div_trial >= {1'b0, sw_q};

  assign sq_trial = {sq_rem_q, sq_src_q[2*wsc_pkg::SqrtW-1 -: 2]};
  assign sq_test  = {1'b0, sq_root_q, 2'b01};
  assign sq_diff  = sq_trial - sq_test;
  assign sq_ge    = sq_trial >= sq_test;

  // mean^2 in Q.16, product of the previous step
  assign msq    = prod_q[62:16];
  assign var_ok = e2_q > {2'b00, msq};

  // magnitude of the signed residual sum, 2^44 for the most negative value
  assign sf_mag = sf_q[wsc_pkg::SfW-1] ? (~sf_q + 45'd1) : sf_q;

  // cut adder: mean + d, then mean - d, saturated to 40 bits signed
  assign mean42  = neg_q ? -$signed({10'b0, m_q}) : $signed({10'b0, m_q});
  assign d42     = $signed({1'b0, prod_q[40:0]});
  assign add_sum = (state_q == wsc_pkg::S_CUT_HI) ? (mean42 + d42) : (mean42 - d42);

  always_comb begin
    if (add_sum[41:39] == 3'b000 || add_sum[41:39] == 3'b111) begin
      cut_sat = add_sum[wsc_pkg::CutW-1:0];
    end else if (add_sum[41]) begin
      cut_sat = {1'b1, {(wsc_pkg::CutW-1){1'b0}}};
    end else begin
      cut_sat = {1'b0, {(wsc_pkg::CutW-1){1'b1}}};
    end
  end

  // clip pass: residual in Q.16 against the stored cuts
  assign r16     = {{12{res_q[wsc_pkg::ResW-1]}}, res_q, 12'b0};
  assign outl    = clip_en_q && ((r16 > up_q) || (r16 < lo_q));
  assign cnt_inc = (outl && (cnt_q < CntW'(MAX_PIXELS))) ? (cnt_q + CntW'(1)) : cnt_q;
  assign cnt_ext = {{wsc_pkg::CntOutW{1'b0}}, cnt_inc};

  // shared multiplier operand select, product registered every cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      wsc_pkg::S_SQ: begin
        mul_a = 33'(res_q);
        mul_b = 33'(res_q);
      end
      wsc_pkg::S_WR: begin
        mul_a = $signed({17'b0, wgt_q});
        mul_b = 33'(res_q);
      end
      wsc_pkg::S_WRR: begin
        mul_a = $signed({17'b0, wgt_q});
        mul_b = $signed({2'b0, rr_q});
      end
      wsc_pkg::S_MSQ: begin
        mul_a = $signed({1'b0, m_q});
        mul_b = $signed({1'b0, m_q});
      end
      // nsig*sigma is held for both cut steps
      wsc_pkg::S_MULD, wsc_pkg::S_CUT_HI: begin
        mul_a = $signed({17'b0, nsig_q});
        mul_b = $signed({8'b0, sq_root_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // --------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wsc_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_d = in_ch.func ? wsc_pkg::S_CLIP : wsc_pkg::S_SQ;
        end
      end
      wsc_pkg::S_SQ:    state_d = wsc_pkg::S_WR;
      wsc_pkg::S_WR:    state_d = wsc_pkg::S_WRR;
      wsc_pkg::S_WRR:   state_d = wsc_pkg::S_ACC;
      wsc_pkg::S_ACC:   state_d = last_q ? wsc_pkg::S_FIN : wsc_pkg::S_IDLE;
      wsc_pkg::S_FIN:   state_d = (sw_q == '0) ? wsc_pkg::S_IDLE : wsc_pkg::S_DIV_M;
      wsc_pkg::S_DIV_M: state_d = (step_q == '0) ? wsc_pkg::S_SAT_M : wsc_pkg::S_DIV_M;
      wsc_pkg::S_SAT_M: state_d = wsc_pkg::S_DIV_E;
      wsc_pkg::S_DIV_E: state_d = (step_q == '0) ? wsc_pkg::S_SAT_E : wsc_pkg::S_DIV_E;
      wsc_pkg::S_SAT_E: state_d = wsc_pkg::S_MSQ;
      wsc_pkg::S_MSQ:   state_d = wsc_pkg::S_VAR;
      wsc_pkg::S_VAR:   state_d = var_ok ? wsc_pkg::S_SQRT : wsc_pkg::S_IDLE;
      wsc_pkg::S_SQRT:  state_d = (step_q == '0) ? wsc_pkg::S_MULD : wsc_pkg::S_SQRT;
      wsc_pkg::S_MULD:  state_d = wsc_pkg::S_CUT_HI;
      wsc_pkg::S_CUT_HI: state_d = wsc_pkg::S_CUT_LO;
      wsc_pkg::S_CUT_LO: state_d = wsc_pkg::S_IDLE;
      wsc_pkg::S_CLIP:  state_d = out_free ? wsc_pkg::S_IDLE : wsc_pkg::S_CLIP;
      default:          state_d = wsc_pkg::S_IDLE;
    endcase
  end

  // ----------------------------------------------------------------- datapath
  always_comb begin
    nsig_d      = cfg_wr ? pwdata[wsc_pkg::NsigW-1:0] : nsig_q;
    sw_d        = sw_q;
    sf_d        = sf_q;
    sf2_d       = sf2_q;
    up_d        = up_q;
    lo_d        = lo_q;
    clip_en_d   = clip_en_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    wgt_d       = wgt_q;
    last_d      = last_q;
    rr_d        = rr_q;
    div_num_d   = div_num_q;
    div_quo_d   = div_quo_q;
    div_rem_d   = div_rem_q;
    sq_src_d    = sq_src_q;
    sq_root_d   = sq_root_q;
    sq_rem_d    = sq_rem_q;
    step_d      = step_q;
    neg_d       = neg_q;
    m_d         = m_q;
    e2_d        = e2_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_wgt_d   = out_wgt_q;
    out_outl_d  = out_outl_q;
    out_cnt_d   = out_cnt_q;
    out_act_d   = out_act_q;
    out_fin_d   = out_fin_q;

    unique case (state_q)
      wsc_pkg::S_IDLE: begin
        if (in_fire) begin
          res_d  = in_ch.residual;
          wgt_d  = in_ch.weight;
          last_d = in_ch.last;
        end
      end
      wsc_pkg::S_SQ: begin
      end
      wsc_pkg::S_WR: begin
        rr_d = prod_q[30:0];
      end
      wsc_pkg::S_WRR: begin
        sf_d = sf_q + prod_q[wsc_pkg::SfW-1:0];
      end
      wsc_pkg::S_ACC: begin
        sf2_d = sf2_q + prod_q[wsc_pkg::Sf2W-1:0];
        sw_d  = sw_q + {12'b0, wgt_q};
      end
      wsc_pkg::S_FIN: begin
        if (sw_q == '0) begin
          clip_en_d = 1'b0;
          sw_d      = '0;
          sf_d      = '0;
          sf2_d     = '0;
          cnt_d     = '0;
        end else begin
          neg_d     = sf_q[wsc_pkg::SfW-1];
          div_num_d = {11'b0, sf_mag, 12'b0};
          div_quo_d = '0;
          div_rem_d = '0;
          step_d    = wsc_pkg::DivLast;
        end
      end
      wsc_pkg::S_DIV_M, wsc_pkg::S_DIV_E: begin
        div_num_d = {div_num_q[wsc_pkg::DivW-2:0], 1'b0};
        div_quo_d = {div_quo_q[wsc_pkg::DivW-2:0], div_ge};
        div_rem_d = div_ge ? div_diff[wsc_pkg::SwW-1:0] : div_trial[wsc_pkg::SwW-1:0];
        step_d    = step_q - 7'd1;
      end
      wsc_pkg::S_SAT_M: begin
        // mean capped at 1.0 * 2^15 in Q.16
        m_d       = (div_quo_q > 68'h8000_0000) ? 32'h8000_0000 : div_quo_q[31:0];
        div_num_d = {sf2_q, 8'b0};
        div_quo_d = '0;
        div_rem_d = '0;
        step_d    = wsc_pkg::DivLast;
      end
      wsc_pkg::S_SAT_E: begin
        e2_d = (div_quo_q > (68'd1 << 48)) ? (49'd1 << 48) : div_quo_q[48:0];
      end
      wsc_pkg::S_MSQ: begin
      end
      wsc_pkg::S_VAR: begin
        if (var_ok) begin
          sq_src_d  = {1'b0, e2_q - {2'b00, msq}};
          sq_root_d = '0;
          sq_rem_d  = '0;
          step_d    = wsc_pkg::SqrtLast;
        end else begin
          clip_en_d = 1'b0;
          sw_d      = '0;
          sf_d      = '0;
          sf2_d     = '0;
          cnt_d     = '0;
        end
      end
      wsc_pkg::S_SQRT: begin
        sq_src_d  = {sq_src_q[2*wsc_pkg::SqrtW-3:0], 2'b00};
        sq_root_d = {sq_root_q[wsc_pkg::SqrtW-2:0], sq_ge};
        sq_rem_d  = sq_ge ? sq_diff[wsc_pkg::SqrtW:0] : sq_trial[wsc_pkg::SqrtW:0];
        step_d    = step_q - 7'd1;
      end
      wsc_pkg::S_MULD: begin
      end
      wsc_pkg::S_CUT_HI: begin
        up_d = cut_sat;
      end
      wsc_pkg::S_CUT_LO: begin
        lo_d      = cut_sat;
        clip_en_d = 1'b1;
        sw_d      = '0;
        sf_d      = '0;
        sf2_d     = '0;
        cnt_d     = '0;
      end
      wsc_pkg::S_CLIP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_wgt_d   = outl ? '0 : wgt_q;
          out_outl_d  = outl;
          out_cnt_d   = cnt_ext[wsc_pkg::CntOutW-1:0];
          out_act_d   = clip_en_q;
          out_fin_d   = last_q;
          cnt_d       = last_q ? '0 : cnt_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------ storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsc_pkg::S_IDLE;
      nsig_q      <= wsc_pkg::NsigReset;
      sw_q        <= '0;
      sf_q        <= '0;
      sf2_q       <= '0;
      up_q        <= '0;
      lo_q        <= '0;
      clip_en_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nsig_q      <= nsig_d;
      sw_q        <= sw_d;
      sf_q        <= sf_d;
      sf2_q       <= sf2_d;
      up_q        <= up_d;
      lo_q        <= lo_d;
      clip_en_q   <= clip_en_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    wgt_q     <= wgt_d;
    last_q    <= last_d;
    prod_q    <= prod_d;
    rr_q      <= rr_d;
    div_num_q <= div_num_d;
    div_quo_q <= div_quo_d;
    div_rem_q <= div_rem_d;
    sq_src_q  <= sq_src_d;
    sq_root_q <= sq_root_d;
    sq_rem_q  <= sq_rem_d;
    step_q    <= step_d;
    neg_q     <= neg_d;
    m_q       <= m_d;
    e2_q      <= e2_d;
    out_wgt_q <= out_wgt_d;
    out_outl_q <= out_outl_d;
    out_cnt_q <= out_cnt_d;
    out_act_q <= out_act_d;
    out_fin_q <= out_fin_d;
  end

  // -------------------------------------------------------------------- ports
  assign in_ch.ready          = (state_q == wsc_pkg::S_IDLE);
  assign out_ch.valid         = out_valid_q;
  assign out_ch.new_weight    = out_wgt_q;
  assign out_ch.is_outlier    = out_outl_q;
  assign out_ch.outlier_count = out_cnt_q;
  assign out_ch.clip_active   = out_act_q;
  assign out_ch.final_res     = out_fin_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == wsc_pkg::NsigIdx) ? {16'b0, nsig_q} : 32'b0;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for weighted_sigma_clip_unit: statistics/clip passes with a
// built-in predictor, random pacing on both channels, nsig_cut over the APB port.
// Depends on wsc_pkg, wsc_in_if, wsc_out_if and the unit itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ResW    = wsc_pkg::ResW;
  localparam int unsigned WgtW    = wsc_pkg::WgtW;
  localparam int unsigned CntOutW = wsc_pkg::CntOutW;
  localparam int unsigned NsigW   = wsc_pkg::NsigW;
  localparam int unsigned SwW     = wsc_pkg::SwW;
  localparam int unsigned SfW     = wsc_pkg::SfW;
  localparam int unsigned Sf2W    = wsc_pkg::Sf2W;
  localparam logic             NsigIdx   = wsc_pkg::NsigIdx;
  localparam logic [NsigW-1:0] NsigReset = wsc_pkg::NsigReset;

  localparam int unsigned MaxPixels   = 4096;
  localparam int unsigned CycleLimit  = 1_000_000;
  // Drain time for the cut computation of a last statistics word, with no result to wait for.
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned RandomWords = 800;
  localparam int unsigned OutlierRun  = 160;
  localparam int unsigned LargeRun    = 64;
  localparam logic [2:0]  NsigAddr    = 3'(4 * NsigIdx);

  localparam logic FuncStats = 1'b0;
  localparam logic FuncClip  = 1'b1;

  localparam logic signed [ResW-1:0] ResMax = 16'sh7FFF;
  localparam logic signed [ResW-1:0] ResMin = 16'sh8000;
  localparam logic [WgtW-1:0]        WgtMax = 16'hFFFF;

  localparam longint          CutMax  = (longint'(1) <<< 39) - 1;
  localparam longint          CutMin  = -CutMax - 1;
  localparam longint unsigned QuotCap = 64'd1 << 40;
  localparam longint unsigned MeanCap = 64'd1 << 31;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_e;

  typedef struct packed {
    logic                   func;
    logic signed [ResW-1:0] residual;
    logic [WgtW-1:0]        weight;
    logic                   last;
  } pixel_t;

  typedef struct packed {
    logic [WgtW-1:0]    new_weight;
    logic               is_outlier;
    logic [CntOutW-1:0] outlier_count;
    logic               clip_active;
    logic               final_res;
  } clip_word_t;

  logic        clk = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  wsc_in_if  in_ch ();
  wsc_out_if out_ch ();

  weighted_sigma_clip_unit #(.MAX_PIXELS(MaxPixels)) DUT (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the unit's sums, cuts, enable and outlier count.
  // ---------------------------------------------------------------------------
  logic [NsigW-1:0] nsig_q88 = NsigReset;
  logic [SwW-1:0]   acc_w    = '0;
  logic [SfW-1:0]   acc_wr   = '0;   // two's complement, wraps at 45 bits
  logic [Sf2W-1:0]  acc_wr2  = '0;
  longint           cut_hi   = 0;
  longint           cut_lo   = 0;
  logic             clip_on  = 1'b0;
  int unsigned      outl_cnt = 0;

  clip_word_t expected_clip_words[$];

  int unsigned mismatch_cnt = 0;
  int unsigned words_sent   = 0;
  int unsigned cycle_cnt    = 0;

  // Pacing knobs, changed per test / per phase of the random part.
  int unsigned gap_max     = 0;
  int unsigned burst_left  = 0;
  stall_mode_e stall_mode  = STALL_NONE;
  logic [7:0]  stall_mask  = 8'hFF;
  logic [2:0]  stall_phase = '0;

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  // floor(num * 2^k / den), integer part capped at 2^40
  function automatic longint unsigned scaled_quot(longint unsigned num,
                                                  longint unsigned den, int unsigned k);
    longint unsigned q, rm;
    q  = num / den;
    rm = num % den;
    if (q >= QuotCap) return QuotCap << k;
    return (q << k) + ((rm << k) / den);
  endfunction

  function automatic longint sat_cut(longint v);
    if (v > CutMax) return CutMax;
    if (v < CutMin) return CutMin;
    return v;
  endfunction

  // Advance the model by one accepted pixel word; queue the clip result if any.
  task automatic compute_clip_result(input pixel_t px);
    longint          r, wr, mean, r16, d;
    longint unsigned w, wr2, mag, m, e2, msq, rad, root, bitv;
    logic            neg, outl;
    clip_word_t      res;
    r = longint'($signed(px.residual));
    w = 64'(px.weight);
    if (px.func == FuncStats) begin
      wr  = longint'(w) * r;
      wr2 = w * 64'(r * r);
      acc_w   = acc_w + SwW'(px.weight);
      acc_wr  = acc_wr + wr[SfW-1:0];
      acc_wr2 = acc_wr2 + wr2[Sf2W-1:0];
      if (px.last) begin
        clip_on = 1'b0;
        if (acc_w != 0) begin
          neg = acc_wr[SfW-1];
          mag = neg ? (64'd1 << SfW) - 64'(acc_wr) : 64'(acc_wr);
          m   = scaled_quot(mag, 64'(acc_w), 12);
          if (m > MeanCap) m = MeanCap;
          e2  = scaled_quot(64'(acc_wr2), 64'(acc_w), 8);
          msq = (m * m) >> 16;
          if (e2 > msq) begin
            // bitwise integer square root of the variance (Q.16 -> sigma Q.8)
            rad  = e2 - msq;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rad) bitv >>= 2;
            while (bitv != 0) begin
              if (rad >= root + bitv) begin
                rad -= root + bitv;
                root = (root >> 1) + bitv;
              end else begin
                root >>= 1;
              end
              bitv >>= 2;
            end
            d      = longint'(64'(nsig_q88) * root);
            mean   = neg ? -longint'(m) : longint'(m);
            cut_hi = sat_cut(mean + d);
            cut_lo = sat_cut(mean - d);
            clip_on = 1'b1;
          end
        end
        acc_w    = '0;
        acc_wr   = '0;
        acc_wr2  = '0;
        outl_cnt = 0;
      end
    end else begin
      r16  = r * 4096;
      outl = clip_on && (r16 > cut_hi || r16 < cut_lo);
      if (outl && outl_cnt < MaxPixels) outl_cnt++;
      res.new_weight    = outl ? '0 : px.weight;
      res.is_outlier    = outl;
      res.outlier_count = CntOutW'(outl_cnt);
      res.clip_active   = clip_on;
      res.final_res     = px.last;
      expected_clip_words.push_back(res);
      if (px.last) outl_cnt = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps (none if
  // gap_max is 0). valid stays high across back-to-back words.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic func, input logic signed [ResW-1:0] res,
                            input logic [WgtW-1:0] wgt, input logic last);
    int unsigned gap;
    pixel_t      px;
    px = '{func: func, residual: res, weight: wgt, last: last};
    if (gap_max != 0 && burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.func     <= px.func;
    in_ch.residual <= px.residual;
    in_ch.weight   <= px.weight;
    in_ch.last     <= px.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    compute_clip_result(px);
  endtask

  // APB read of nsig_cut; value is taken at the end of the access phase.
  task automatic check_nsig_reg(input logic [NsigW-1:0] exp_v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= NsigAddr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(exp_v))
      note_mismatch($sformatf("nsig_cut readback expected %0d got %0d", exp_v, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Only written while idle: all results in, then room for a cut computation.
  task automatic set_nsig(input logic [NsigW-1:0] value);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_clip_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NsigAddr;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    nsig_q88 = value;
    @(posedge clk);
    check_nsig_reg(value);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready follows the current stall mode.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    case (stall_mode)
      STALL_NONE:   out_ch.ready <= 1'b1;
      STALL_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default:      out_ch.ready <= stall_mask[stall_phase];
    endcase
    stall_phase <= stall_phase + 3'd1;
  end

  // Result checker: each accepted word against the oldest expectation.
  clip_word_t got_w, exp_w;
  always @(posedge clk) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got_w = '{new_weight: out_ch.new_weight, is_outlier: out_ch.is_outlier,
                outlier_count: out_ch.outlier_count, clip_active: out_ch.clip_active,
                final_res: out_ch.final_res};
      if (expected_clip_words.size() == 0) begin
        note_mismatch($sformatf("result word with none expected: weight %0d count %0d",
                                got_w.new_weight, got_w.outlier_count));
      end else begin
        exp_w = expected_clip_words.pop_front();
        if (got_w.new_weight !== exp_w.new_weight)
          note_mismatch($sformatf("new_weight expected %0d got %0d",
                                  exp_w.new_weight, got_w.new_weight));
        if (got_w.is_outlier !== exp_w.is_outlier)
          note_mismatch($sformatf("is_outlier expected %0d got %0d",
                                  exp_w.is_outlier, got_w.is_outlier));
        if (got_w.outlier_count !== exp_w.outlier_count)
          note_mismatch($sformatf("outlier_count expected %0d got %0d",
                                  exp_w.outlier_count, got_w.outlier_count));
        if (got_w.clip_active !== exp_w.clip_active)
          note_mismatch($sformatf("clip_active expected %0d got %0d",
                                  exp_w.clip_active, got_w.clip_active));
        if (got_w.final_res !== exp_w.final_res)
          note_mismatch($sformatf("final_res expected %0d got %0d",
                                  exp_w.final_res, got_w.final_res));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [ResW-1:0] pick_residual(int center, int spread);
    int v;
    if ($urandom_range(0, 7) == 0) return ResW'($urandom);   // stray pixel
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return ResW'(v);
  endfunction

  function automatic logic [WgtW-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return WgtMax;
      2:       return WgtW'($urandom_range(1, 255));
      default: return WgtW'($urandom);
    endcase
  endfunction

  // One pass of n words around center; last flagged on the final word if asked.
  task automatic send_pass(input logic func, input int unsigned n, input int center,
                           input int spread, input logic with_last);
    for (int unsigned i = 0; i < n; i++)
      send_pixel(func, pick_residual(center, spread), pick_weight(),
                 with_last && (i == n - 1));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // nsig_cut reset value, and clip words before any statistics: clipping off.
  task automatic test_reset_state();
    gap_max    = 2;
    stall_mode = STALL_RANDOM;
    check_nsig_reg(NsigReset);
    @(posedge clk);
    send_pixel(FuncClip, ResMax, WgtMax, 1'b0);
    send_pixel(FuncClip, ResMin, 16'h0000, 1'b1);
  endtask

  // Field extremes through both passes with a tight threshold so the extremes
  // are outliers; includes an outlier whose weight was already zero.
  task automatic test_clip_extremes();
    stall_mode = STALL_PATTERN;
    stall_mask = 8'b1011_0101;
    set_nsig(16'd128);
    send_pixel(FuncStats, ResMin, WgtMax, 1'b0);
    send_pixel(FuncStats, ResMax, WgtMax, 1'b0);
    send_pixel(FuncStats, 16'sd0, 16'h0000, 1'b0);
    send_pixel(FuncStats, 16'sd16, 16'h1000, 1'b1);
    send_pixel(FuncClip, ResMax, 16'h0001, 1'b0);
    send_pixel(FuncClip, ResMin, 16'h0000, 1'b0);
    send_pixel(FuncClip, 16'sd0, 16'd12345, 1'b0);
    send_pixel(FuncClip, ResMax, WgtMax, 1'b1);
  endtask

  // Zero weight sum, then zero variance: both leave clipping disabled.
  task automatic test_degenerate_stats();
    send_pixel(FuncStats, 16'sd100, 16'h0000, 1'b0);
    send_pixel(FuncStats, -16'sd5, 16'h0000, 1'b1);
    send_pixel(FuncClip, ResMax, WgtMax, 1'b1);
    send_pixel(FuncStats, 16'sd50, 16'h1000, 1'b0);
    send_pixel(FuncStats, 16'sd50, 16'h2000, 1'b1);
    send_pixel(FuncClip, ResMin, 16'h0001, 1'b1);
  endtask

  // nsig 0 puts both cuts on the mean; every far pixel is an outlier and the
  // count climbs word by word through one long clip pass.
  task automatic test_outlier_count();
    gap_max    = 1;
    stall_mode = STALL_RANDOM;
    set_nsig(16'd0);
    send_pixel(FuncStats, 16'sd0, 16'h1000, 1'b0);
    send_pixel(FuncStats, 16'sd16, 16'h1000, 1'b1);
    for (int unsigned i = 0; i < OutlierRun; i++)
      send_pixel(FuncClip, i[0] ? ResMin : ResMax, WgtW'($urandom),
                 i == OutlierRun - 1);
  endtask

  // Full-scale residuals at near-full weight push all three sums far from
  // zero; nsig at its maximum stretches the cuts to many sigmas.
  task automatic test_large_sums();
    gap_max    = 0;
    stall_mode = STALL_NONE;
    set_nsig(16'hFFFF);
    for (int unsigned i = 0; i < LargeRun; i++)
      send_pixel(FuncStats, ($urandom_range(0, 15) == 0) ? ResMax : ResMin,
                 WgtW'($urandom_range(60000, 65535)), i == LargeRun - 1);
    send_pass(FuncClip, 8, 0, 32768, 1'b1);
  endtask

  // Mostly well-formed stats+clip passes with random content; the rest is
  // noise, clip passes on stale cuts and statistics passes cut short.
  task automatic run_random_traffic();
    int unsigned round_no, kind, n_stats, start_cnt;
    int          center, spread;
    round_no  = 0;
    start_cnt = words_sent;
    while (words_sent - start_cnt < RandomWords) begin
      if (round_no % 12 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_max = 0;
          1:       gap_max = 3;
          default: gap_max = 8;
        endcase
        stall_mode = stall_mode_e'($urandom_range(0, 2));
        stall_mask = 8'($urandom) | 8'h01;
      end
      if (round_no % 10 == 5) begin
        case ($urandom_range(0, 6))
          0:       set_nsig(16'd0);
          1:       set_nsig(16'hFFFF);
          2:       set_nsig(NsigReset);
          3:       set_nsig(16'd256);
          4:       set_nsig(16'd512);
          5:       set_nsig(16'd768);
          default: set_nsig(NsigW'($urandom));
        endcase
      end
      center  = int'($urandom_range(0, 60000)) - 30000;
      spread  = 1 << (4 * $urandom_range(0, 3));
      n_stats = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                            : $urandom_range(1, 12);
      kind    = $urandom_range(0, 9);
      if (kind <= 6) begin
        send_pass(FuncStats, n_stats, center, spread, 1'b1);
        send_pass(FuncClip, $urandom_range(1, 12), center, 2 * spread, 1'b1);
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 6))
          send_pixel(1'($urandom), ResW'($urandom), WgtW'($urandom), 1'($urandom));
      end else if (kind == 8) begin
        send_pass(FuncClip, $urandom_range(1, 12), center, 2 * spread, 1'b1);
      end else begin
        // sums carry into the next statistics pass
        send_pass(FuncStats, n_stats, center, spread, 1'b0);
        send_pass(FuncClip, $urandom_range(1, 6), center, 2 * spread, 1'b0);
      end
      round_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= FuncStats;
    in_ch.residual <= '0;
    in_ch.weight   <= '0;
    in_ch.last     <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_clip_extremes();
    test_degenerate_stats();
    test_outlier_count();
    test_large_sums();
    run_random_traffic();

    in_ch.valid <= 1'b0;
    while (expected_clip_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
